// ----- hw/rtl/cdf_pkg.sv -----
// Shared types, constants and the tap weight table for the counter delta filter.
`timescale 1ns / 1ps

package cdf_pkg;

  // Weights are unsigned Q0.16, so the fractional part of a sum is 16 bits wide.
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned LEVEL_W  = 16;

  // Pipeline controls that the top level hands to each channel.
  typedef struct packed {
    logic load;   // take a new reading into the delta register
    logic shift;  // move the registered delta into the chain of cells
  } cdf_ctrl_t;

  // Weight of the tap that holds the delta of the given age (0 is the newest).
  // The ten weights add up to exactly one; older taps weigh nothing.
  function automatic logic [WEIGHT_W-1:0] tap_weight(input int unsigned age);
    logic [WEIGHT_W-1:0] w;
    unique case (age)
      0:       w = 16'd45877;
      1:       w = 16'd9830;
      2:       w = 16'd3277;
      3:       w = 16'd1638;
      4:       w = 16'd1638;
      5:       w = 16'd819;
      6:       w = 16'd819;
      7:       w = 16'd655;
      8:       w = 16'd655;
      9:       w = 16'd328;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/counter_delta_fir_three_channel_top.sv -----
// Top level of the three-channel counter delta smoothing filter.
`timescale 1ns / 1ps

//  Channel  | Direction | Ports                                   | Handshake
//  ---------+-----------+-----------------------------------------+----------------------
//  input    | in        | in_left_count, in_middle_count,         | in_valid / in_ready
//           |           | in_right_count                          |
//  result   | out       | out_left_level, out_middle_level,       | out_valid / out_ready
//           |           | out_right_level                         |
//
//  A word is taken every cycle when the result side keeps up. Its deltas are first
//  registered in the delta register and then its sum in the tap chain, whose first
//  cell drives the outputs.
//  Synchronous active-low reset clears the previous readings and every partial sum,
//  which is the same as an all-zero history.
//  When out_ready is low the finished result holds in the chain and the delta register
//  still takes one further word, so the input side only stalls once both are full.

module counter_delta_fir_three_channel_top #(
  parameter int unsigned TAPS         = 10,
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [COUNTER_BITS-1:0]     in_left_count,
  input  logic [COUNTER_BITS-1:0]     in_middle_count,
  input  logic [COUNTER_BITS-1:0]     in_right_count,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cdf_pkg::LEVEL_W-1:0] out_left_level,
  output logic [cdf_pkg::LEVEL_W-1:0] out_middle_level,
  output logic [cdf_pkg::LEVEL_W-1:0] out_right_level
);
  import cdf_pkg::*;

  // Stage one holds the deltas; stage two is the tap chain, whose first cell carries
  // the finished sum and so acts as the output register.
  logic      delta_valid_r;
  logic      delta_valid_nxt;
  logic      sum_valid_r;
  logic      sum_valid_nxt;
  cdf_ctrl_t ctrl;

  // The chain may advance when it is empty or its result is being taken this cycle.
  assign ctrl.shift = delta_valid_r && (!sum_valid_r || out_ready);
  assign in_ready   = !delta_valid_r || ctrl.shift;
  assign ctrl.load  = in_valid && in_ready;

  assign delta_valid_nxt = ctrl.load || (delta_valid_r && !ctrl.shift);
  assign sum_valid_nxt   = ctrl.shift || (sum_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_valid_r <= 1'b0;
      sum_valid_r   <= 1'b0;
    end else begin
      delta_valid_r <= delta_valid_nxt;
      sum_valid_r   <= sum_valid_nxt;
    end
  end

  assign out_valid = sum_valid_r;

  cdf_channel #(
    .TAPS         (TAPS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_left (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .count (in_left_count),
    .level (out_left_level)
  );

  cdf_channel #(
    .TAPS         (TAPS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_middle (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .count (in_middle_count),
    .level (out_middle_level)
  );

  cdf_channel #(
    .TAPS         (TAPS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_right (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .count (in_right_count),
    .level (out_right_level)
  );

endmodule

// ----- hw/rtl/cdf_cell.sv -----
// One tap cell of the transposed filter chain: a constant product plus a partial sum.
`timescale 1ns / 1ps

module cdf_cell #(
  parameter int unsigned COUNTER_BITS = 16,
  parameter int unsigned ACC_W        = 33,
  parameter logic [15:0] WEIGHT       = 16'd0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    shift,
  input  logic [COUNTER_BITS-1:0] delta,
  input  logic [ACC_W-1:0]        sum_in,
  output logic [ACC_W-1:0]        sum_out
);
  import cdf_pkg::*;

  localparam int unsigned PROD_W = COUNTER_BITS + WEIGHT_W;

  logic [PROD_W-1:0] product;
  logic [ACC_W-1:0]  sum_r;
  logic [ACC_W-1:0]  sum_nxt;

  assign product = PROD_W'(delta) * PROD_W'(WEIGHT);
  assign sum_nxt = sum_in + ACC_W'(product);
  assign sum_out = sum_r;

  // The partial sum stands for the older history, so reset must clear it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (shift) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// ----- hw/rtl/cdf_channel.sv -----
// One channel: wrapping delta of the counter, chain of tap cells and output saturation.
`timescale 1ns / 1ps

module cdf_channel #(
  parameter int unsigned TAPS         = 10,
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cdf_pkg::cdf_ctrl_t      ctrl,
  input  logic [COUNTER_BITS-1:0] count,
  output logic [cdf_pkg::LEVEL_W-1:0] level
);
  import cdf_pkg::*;

  // The weights sum to one, so the full sum stays below 2^(COUNTER_BITS+16).
  localparam int unsigned ACC_W   = COUNTER_BITS + WEIGHT_W + 1;
  localparam int unsigned WHOLE_W = ACC_W - WEIGHT_W;

  logic [COUNTER_BITS-1:0] prev_r;
  logic [COUNTER_BITS-1:0] delta_r;
  logic [COUNTER_BITS-1:0] delta_nxt;
  logic [ACC_W-1:0]        chain [TAPS+1];
  logic [WHOLE_W-1:0]      whole;

  // Subtraction at the counter width wraps exactly as the counter does.
  assign delta_nxt = count - prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (ctrl.load) begin
      prev_r <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      delta_r <= delta_nxt;
    end
  end

  // Cell k weighs the delta of age k; the oldest cell starts from zero.
  assign chain[TAPS] = '0;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    cdf_cell #(
      .COUNTER_BITS (COUNTER_BITS),
      .ACC_W        (ACC_W),
      .WEIGHT       (tap_weight(k))
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (ctrl.shift),
      .delta   (delta_r),
      .sum_in  (chain[k+1]),
      .sum_out (chain[k])
    );
  end

  // Drop the fraction, then clamp to the level range.
  assign whole = chain[0][ACC_W-1:WEIGHT_W];

  if (WHOLE_W > LEVEL_W) begin : g_sat
    assign level = (|whole[WHOLE_W-1:LEVEL_W]) ? '1 : whole[LEVEL_W-1:0];
  end else begin : g_nosat
    assign level = LEVEL_W'(whole);
  end

endmodule
